[rtl/tts_pkg.sv]
// Shared types, sizes and text conversion helpers for the trace buffer.
// No dependencies.
package tts_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int TAG_W   = 8;
  localparam int TICK_W  = 24;
  localparam int STAMP_W = TAG_W + TICK_W;
  localparam int TEXT_W  = 64;
  localparam int LEND_W  = 16;

  localparam logic [LEND_W-1:0] LINE_END    = 16'h0D0A;
  localparam logic [7:0]        ASCII_ZERO  = 8'h30;
  localparam logic [7:0]        ASCII_A_OFS = 8'h37;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [STAMP_W-1:0]   stamp;
  } cmd_t;

  function automatic logic [7:0] nib_to_ascii(logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      return ASCII_ZERO + ext;
    end
    return ASCII_A_OFS + ext;
  endfunction

  function automatic logic [TEXT_W-1:0] stamp_to_text(logic [STAMP_W-1:0] stamp);
    logic [TEXT_W-1:0] text;
    text = '0;
    for (int k = 0; k < 8; k++) begin
      text[TEXT_W-1-8*k -: 8] = nib_to_ascii(stamp[STAMP_W-1-4*k -: 4]);
    end
    return text;
  endfunction

endpackage

[rtl/tts_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tts_front.sv]
// Front end: accepts requests, builds the stamp and queues the command.
// Depends on tts_pkg.
module tts_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic [tts_pkg::TAG_W-1:0] tag_i,
  input  logic [tts_pkg::TICK_W-1:0] ticks_i,
  output logic                      q_valid_o,
  output tts_pkg::cmd_t             q_entry_o,
  input  logic                      q_pop_i
);

  tts_pkg::cmd_t                 q_mem_q [tts_pkg::QDEPTH];
  logic [tts_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tts_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tts_pkg::QCNT_W-1:0]    fill_q, fill_d;
  logic                          push;
  logic                          pop;
  tts_pkg::cmd_t                 entry;

  assign in_stall_o = (fill_q == tts_pkg::QCNT_W'(tts_pkg::QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_entry_o  = q_mem_q[rd_ptr_q];

  always_comb begin
    entry.cmd   = tts_pkg::cmd_e'(command_i);
    entry.stamp = {tag_i, ticks_i};
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tts_pkg::QPTR_W'(tts_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == tts_pkg::QPTR_W'(tts_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

[rtl/tts_back.sv]
// Back end: stores stamps in the RAM and drains them as hex text lines on flush.
// Depends on tts_pkg and tts_ram.
module tts_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  tts_pkg::cmd_t               q_entry_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tts_pkg::TEXT_W-1:0]  hex_text_o,
  output logic [tts_pkg::LEND_W-1:0]  line_end_o,
  output logic                        last_o
);

  logic [tts_pkg::CNT_W-1:0]   count_q, count_d;
  logic [tts_pkg::IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic                        draining_q, draining_d;
  logic                        avail_q, avail_d;
  logic                        last_pend_q;
  logic                        out_valid_q, out_valid_d;
  logic [tts_pkg::TEXT_W-1:0]  hex_q;
  logic                        last_q;
  logic                        we, start, load, rd_en, rd_last;
  logic [tts_pkg::STAMP_W-1:0] rdata;

  assign q_pop_o = q_valid_i && !draining_q;
  assign we      = q_pop_o && (q_entry_i.cmd == tts_pkg::CMD_STORE)
                   && (count_q < tts_pkg::CNT_W'(tts_pkg::DEPTH));
  assign start   = q_pop_o && (q_entry_i.cmd == tts_pkg::CMD_FLUSH) && (count_q != '0);
  assign load    = avail_q && (!out_valid_q || !out_stall_i);
  assign rd_en   = draining_q && (!avail_q || load);
  assign rd_last = (tts_pkg::CNT_W'(rd_idx_q) + tts_pkg::CNT_W'(1)) == count_q;

  tts_ram #(
    .WIDTH(tts_pkg::STAMP_W),
    .DEPTH(tts_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[tts_pkg::IDX_W-1:0]),
    .wdata_i (q_entry_i.stamp),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    draining_d  = draining_q;
    avail_d     = avail_q;
    out_valid_d = out_valid_q;
    if (we) begin
      count_d = count_q + 1'b1;
    end
    if (start) begin
      draining_d = 1'b1;
      rd_idx_d   = '0;
    end
    if (rd_en) begin
      rd_idx_d = rd_idx_q + 1'b1;
      avail_d  = 1'b1;
      if (rd_last) begin
        draining_d = 1'b0;
        count_d    = '0;
      end
    end else if (load) begin
      avail_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      draining_q  <= 1'b0;
      avail_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      draining_q  <= draining_d;
      avail_q     <= avail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      last_pend_q <= rd_last;
    end
    if (load) begin
      hex_q  <= tts_pkg::stamp_to_text(rdata);
      last_q <= last_pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hex_text_o  = hex_q;
  assign line_end_o  = tts_pkg::LINE_END;
  assign last_o      = last_q;

endmodule

[rtl/tagged_timestamp_trace_buffer.sv]
// Trace buffer that keeps up to tts_pkg::DEPTH tagged stamps (tag in bits 31..24, low
// 24 tick bits below) and prints them as ASCII hex lines on flush. The front end takes
// one request per cycle while not stalled into a two-entry command queue; a store is
// written to the RAM as it leaves the queue. A flush of N stamps gives N lines, one per
// cycle while the output is not stalled, each through the RAM read register and then the
// output register; the single read port of the stamp RAM sets the rate. While a flush
// drains, the queue fills and the input stalls. Stores to a full buffer are dropped;
// a flush of an empty buffer gives no line. Depends on tts_pkg, tts_front and tts_back.
module tagged_timestamp_trace_buffer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [tts_pkg::TAG_W-1:0]   tag_i,
  input  logic [tts_pkg::TICK_W-1:0]  ticks_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tts_pkg::TEXT_W-1:0]  hex_text_o,
  output logic [tts_pkg::LEND_W-1:0]  line_end_o,
  output logic                        last_o
);

  logic          q_valid;
  logic          q_pop;
  tts_pkg::cmd_t q_entry;

  tts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .tag_i      (tag_i),
    .ticks_i    (ticks_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  tts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hex_text_o  (hex_text_o),
    .line_end_o  (line_end_o),
    .last_o      (last_o)
  );

endmodule

[rtl/tts_checker.sv]
// Port-level checks for the trace buffer, bound to the top level.
// Depends on tts_pkg and tagged_timestamp_trace_buffer.
module tts_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        command_i,
  input logic [tts_pkg::TAG_W-1:0]   tag_i,
  input logic [tts_pkg::TICK_W-1:0]  ticks_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [tts_pkg::TEXT_W-1:0]  hex_text_o,
  input logic [tts_pkg::LEND_W-1:0]  line_end_o,
  input logic                        last_o
);

  function automatic logic is_hex_char(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_hex_text(logic [tts_pkg::TEXT_W-1:0] t);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < 8; k++) begin
      ok = ok && is_hex_char(t[8*k +: 8]);
    end
    return ok;
  endfunction

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hex_text_o) && $stable(last_o))
    else $error("output payload changed while stalled");

  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_end_o == tts_pkg::LINE_END)
    else $error("line terminator is not CR LF");

  a_hex_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_hex_text(hex_text_o))
    else $error("output text holds a non hex character");

endmodule

bind tagged_timestamp_trace_buffer tts_checker u_tts_checker (.*);

[test/tb_tagged_timestamp_trace_buffer.sv]
// Self-checking testbench for tagged_timestamp_trace_buffer: stores and flushes
// with random idling on both sides, each output line checked against an in-bench model.
// Depends on tts_pkg and the trace buffer RTL.
module tb_tagged_timestamp_trace_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_ITEMS   = 150;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    tts_pkg::cmd_e               cmd;
    logic [tts_pkg::TAG_W-1:0]   tag;
    logic [tts_pkg::TICK_W-1:0]  ticks;
    logic [1:0]                  mode;
    bit                          drain;
  } trace_req_t;

  typedef struct {
    logic [tts_pkg::TEXT_W-1:0] text;
    logic [tts_pkg::LEND_W-1:0] lend;
    logic                       last;
  } trace_line_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         command_i = 1'b0;
  logic [tts_pkg::TAG_W-1:0]    tag_i = '0;
  logic [tts_pkg::TICK_W-1:0]   ticks_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [tts_pkg::TEXT_W-1:0]   hex_text_o;
  logic [tts_pkg::LEND_W-1:0]   line_end_o;
  logic                         last_o;

  trace_req_t                   pending_reqs[$];
  trace_line_t                  expected_lines[$];
  logic [tts_pkg::STAMP_W-1:0]  stamp_mem[tts_pkg::DEPTH];
  int unsigned                  stamp_cnt;
  logic [1:0]                   rx_mode = 2'd0;
  int unsigned                  cycles, errors;
  int unsigned                  n_stores, n_flushes, n_empty_flushes, n_dropped, n_lines;

  tagged_timestamp_trace_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .tag_i       (tag_i),
    .ticks_i     (ticks_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hex_text_o  (hex_text_o),
    .line_end_o  (line_end_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [tts_pkg::TEXT_W-1:0] stamp_hex(
      logic [tts_pkg::STAMP_W-1:0] stamp);
    logic [tts_pkg::TEXT_W-1:0] text;
    logic [3:0]                 nib;
    text = '0;
    for (int i = 7; i >= 0; i--) begin
      nib  = stamp[4*i +: 4];
      text = {text[tts_pkg::TEXT_W-9:0],
              (nib < 4'd10) ? (8'd48 + nib) : (8'd65 + nib - 8'd10)};
    end
    return text;
  endfunction

  function automatic int unsigned idle_pct(logic [1:0] mode, bit rx);
    if (mode == 2'd3) return 16;
    if (mode == (rx ? 2'd2 : 2'd1)) return 79;
    return 0;
  endfunction

  task automatic apply_request(logic cmd, logic [tts_pkg::TAG_W-1:0] tag,
                               logic [tts_pkg::TICK_W-1:0] ticks);
    trace_line_t line;
    if (cmd == tts_pkg::CMD_STORE) begin
      n_stores++;
      if (stamp_cnt < tts_pkg::DEPTH) begin
        stamp_mem[stamp_cnt] = {tag, ticks};
        stamp_cnt++;
      end else begin
        n_dropped++;
      end
    end else begin
      n_flushes++;
      if (stamp_cnt == 0) n_empty_flushes++;
      for (int unsigned i = 0; i < stamp_cnt; i++) begin
        line.text = stamp_hex(stamp_mem[i]);
        line.lend = tts_pkg::LINE_END;
        line.last = (i + 1 == stamp_cnt);
        expected_lines.push_back(line);
      end
      stamp_cnt = 0;
    end
  endtask

  task automatic report_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0d: %s", cycles, msg);
  endtask

  task automatic add_req(tts_pkg::cmd_e cmd, logic [tts_pkg::TAG_W-1:0] tag,
                         logic [tts_pkg::TICK_W-1:0] ticks, logic [1:0] mode, bit drain);
    trace_req_t r;
    r.cmd   = cmd;
    r.tag   = tag;
    r.ticks = ticks;
    r.mode  = mode;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_request(command_i, tag_i, ticks_i);
        void'(pending_reqs.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain && expected_lines.size() != 0) &&
            $urandom_range(99) >= idle_pct(pending_reqs[0].mode, 1'b0)) begin
          in_valid_i <= 1'b1;
          command_i  <= pending_reqs[0].cmd;
          tag_i      <= pending_reqs[0].tag;
          ticks_i    <= pending_reqs[0].ticks;
          rx_mode    <= pending_reqs[0].mode;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    trace_line_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_lines++;
        if (expected_lines.size() == 0) begin
          report_error($sformatf("unexpected line text=%h end=%h last=%b",
                                 hex_text_o, line_end_o, last_o));
        end else begin
          want = expected_lines.pop_front();
          if (hex_text_o !== want.text || line_end_o !== want.lend || last_o !== want.last)
            report_error($sformatf("line %0d: exp text=%h end=%h last=%b, got %h %h %b",
                                   n_lines, want.text, want.lend, want.last,
                                   hex_text_o, line_end_o, last_o));
        end
      end
      out_stall_i <= ($urandom_range(99) < idle_pct(rx_mode, 1'b1));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned burst, nst;
    logic [1:0]  mode;
    bit          drain;

    // directed: extremes, digit/letter mix, empty flush, single-entry flush
    add_req(tts_pkg::CMD_STORE, 8'h00, 24'h000000, 2'd0, 1'b0);
    add_req(tts_pkg::CMD_STORE, 8'hFF, 24'hFFFFFF, 2'd0, 1'b0);
    add_req(tts_pkg::CMD_STORE, 8'hA5, 24'h5A5A5A, 2'd0, 1'b0);
    add_req(tts_pkg::CMD_STORE, 8'h0F, 24'h0F0F0F, 2'd0, 1'b0);
    add_req(tts_pkg::CMD_FLUSH, 8'h00, 24'h000000, 2'd0, 1'b0);
    add_req(tts_pkg::CMD_FLUSH, 8'hFF, 24'hFFFFFF, 2'd0, 1'b0);
    add_req(tts_pkg::CMD_STORE, 8'h3C, 24'h123456, 2'd0, 1'b1);
    add_req(tts_pkg::CMD_FLUSH, 8'h5A, 24'hA5A5A5, 2'd0, 1'b0);
    add_req(tts_pkg::CMD_STORE, 8'hC3, 24'h89ABCD, 2'd0, 1'b0);
    add_req(tts_pkg::CMD_STORE, 8'h12, 24'hFEDCBA, 2'd0, 1'b0);
    add_req(tts_pkg::CMD_FLUSH, 8'h00, 24'h000000, 2'd0, 1'b0);

    // random bursts of stores closed by a flush; one burst overfills the store
    burst = 0;
    while (pending_reqs.size() < NUM_ITEMS) begin
      burst++;
      mode  = burst[1:0];
      drain = (burst % 5 == 0);
      if (burst == 2) nst = $urandom_range(tts_pkg::DEPTH + 1, tts_pkg::DEPTH + 4);
      else if ($urandom_range(9) == 0) nst = 0;
      else nst = $urandom_range(1, 8);
      for (int unsigned i = 0; i < nst; i++) begin
        add_req(tts_pkg::CMD_STORE, tts_pkg::TAG_W'($urandom), tts_pkg::TICK_W'($urandom),
                mode, drain && i == 0);
      end
      add_req(tts_pkg::CMD_FLUSH, tts_pkg::TAG_W'($urandom), tts_pkg::TICK_W'($urandom),
              mode, drain && nst == 0);
      if ($urandom_range(7) == 0)
        add_req(tts_pkg::CMD_FLUSH, tts_pkg::TAG_W'($urandom), tts_pkg::TICK_W'($urandom),
                mode, 1'b0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || expected_lines.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_lines.size() != 0)
      report_error($sformatf("%0d lines never arrived", expected_lines.size()));

    $display("Run: %0d stores (%0d dropped when full), %0d flushes (%0d empty).",
             n_stores, n_dropped, n_flushes, n_empty_flushes);
    $display("Checked %0d lines in %0d cycles, %0d errors.", n_lines, cycles, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
